FILE: design/rtcc_pkg.sv
// rtcc_pkg: shared types and constants for the bus real-time clock card core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtcc_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_BRST  = 2'd3
    } action_t;

    // register offsets within the card space
    localparam logic [3:0] OFF_STATUS  = 4'd0;
    localparam logic [3:0] OFF_SEC_HI  = 4'd1;
    localparam logic [3:0] OFF_SEC_MID = 4'd2;
    localparam logic [3:0] OFF_SEC_LO  = 4'd3;
    localparam logic [3:0] OFF_MSEC    = 4'd4;
    localparam logic [3:0] OFF_START   = 4'd5;
    localparam logic [3:0] OFF_STOP    = 4'd6;
    localparam logic [3:0] OFF_ADV1    = 4'd7;
    localparam logic [3:0] OFF_ADV2    = 4'd8;
    localparam logic [3:0] OFF_IRQ_EN  = 4'd9;

    // configuration register indexes
    localparam logic CFG_LEAP = 1'b0;
    localparam logic CFG_STOP = 1'b1;

    localparam int SEC_W = 25;
    localparam logic [SEC_W-1:0] SEC_ADV2_STEP = 25'h1000;

    localparam logic [9:0] US_SUB_LAST = 10'd999;
    localparam logic [3:0] DIGIT_LAST  = 4'd9;
    localparam logic [7:0] RD_IDLE     = 8'hff;

endpackage

`default_nettype wire

FILE: design/bus_realtime_clock_card_core.sv
// bus_realtime_clock_card_core: real-time clock card behind bus registers
// depends on rtcc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is a microsecond tick, a register read, a register write or
// a bus reset; each one yields exactly one result beat (read_data, irq_line).
// Both channels are valid/ready. The clock state is updated at the edge that
// accepts the beat, and the result is registered in an output slot; one beat
// can be taken every cycle while an output slot is free.
// Throughput is set by the single register stage between the bus side and the
// output; the seconds add and the decimal digit counters fit in that cycle.
// A second output slot catches one result while the receiver stalls, so a
// beat is still taken in that cycle; with both slots full, in_ready drops
// until out_ready returns. The microsecond count is held as decimal digits
// (sub-millisecond, ms ones, ms tens, tenths) so reads need no divider.
// Config (leap, stop-allowed switches) is written via cfg_write/cfg_index/
// cfg_data; the user does so only while idle, the block does not enforce it.
// After reset: clock runs from zero, interrupts disabled, output slots empty.
module bus_realtime_clock_card_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    input  wire logic [3:0] register_offset,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic            irq_line
);

    localparam int SW = rtcc_pkg::SEC_W;

    logic          leap_reg;
    logic          stop_ok_reg;
    logic [SW-1:0] sec_reg,      sec_next;
    logic [9:0]    us_sub_reg,   us_sub_next;
    logic [3:0]    ms_ones_reg,  ms_ones_next;
    logic [3:0]    ms_tens_reg,  ms_tens_next;
    logic [3:0]    tenths_reg,   tenths_next;
    logic          running_reg,  running_next;
    logic          irq_en_reg,   irq_en_next;
    logic          irq_act_reg,  irq_act_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg,  out_data_next;
    logic          out_irq_reg,   out_irq_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [7:0]    skid_data_reg,  skid_data_next;
    logic          skid_irq_reg,   skid_irq_next;

    logic          in_fire;
    logic          do_cmd;
    logic [3:0]    cmd_off;
    logic [7:0]    rd_val;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign irq_line  = out_irq_reg;

    // state update for one beat
    always_comb
    begin
        sec_next     = sec_reg;
        us_sub_next  = us_sub_reg;
        ms_ones_next = ms_ones_reg;
        ms_tens_next = ms_tens_reg;
        tenths_next  = tenths_reg;
        running_next = running_reg;
        irq_en_next  = irq_en_reg;
        irq_act_next = irq_act_reg;
        rd_val       = rtcc_pkg::RD_IDLE;
        do_cmd       = 1'b0;
        cmd_off      = register_offset;

        case (rtcc_pkg::action_t'(action))
            rtcc_pkg::ACT_TICK:
            begin
                if (running_reg)
                begin
                    if (us_sub_reg != rtcc_pkg::US_SUB_LAST)
                        us_sub_next = us_sub_reg + 10'd1;
                    else
                    begin
                        us_sub_next = '0;
                        if (ms_ones_reg != rtcc_pkg::DIGIT_LAST)
                            ms_ones_next = ms_ones_reg + 4'd1;
                        else
                        begin
                            ms_ones_next = '0;
                            if (ms_tens_reg != rtcc_pkg::DIGIT_LAST)
                                ms_tens_next = ms_tens_reg + 4'd1;
                            else
                            begin
                                ms_tens_next = '0;
                                if (tenths_reg != rtcc_pkg::DIGIT_LAST)
                                    tenths_next = tenths_reg + 4'd1;
                                else
                                begin
                                    // second rollover
                                    tenths_next  = '0;
                                    sec_next     = sec_reg + SW'(1);
                                    irq_act_next = irq_en_reg;
                                end
                            end
                        end
                    end
                end
            end
            rtcc_pkg::ACT_READ:
            begin
                case (register_offset)
                    rtcc_pkg::OFF_STATUS:
                        rd_val = {!irq_act_reg, leap_reg, 1'b1, sec_reg[24:20]};
                    rtcc_pkg::OFF_SEC_HI:  rd_val = sec_reg[19:12];
                    rtcc_pkg::OFF_SEC_MID: rd_val = sec_reg[11:4];
                    rtcc_pkg::OFF_SEC_LO:  rd_val = {sec_reg[3:0], tenths_reg};
                    rtcc_pkg::OFF_MSEC:    rd_val = {ms_tens_reg, ms_ones_reg};
                    default:               do_cmd = 1'b1;
                endcase
            end
            rtcc_pkg::ACT_WRITE:
            begin
                if (register_offset == rtcc_pkg::OFF_IRQ_EN)
                    irq_en_next = write_data[0];
                else
                    do_cmd = 1'b1;
            end
            default:
                irq_en_next = 1'b0;
        endcase

        if (do_cmd)
        begin
            case (cmd_off)
                rtcc_pkg::OFF_START: running_next = 1'b1;
                rtcc_pkg::OFF_STOP:  running_next = !stop_ok_reg;
                rtcc_pkg::OFF_ADV1:
                begin
                    if (!running_reg)
                        sec_next = sec_reg + SW'(1);
                    irq_act_next = 1'b0;
                end
                rtcc_pkg::OFF_ADV2:
                begin
                    if (!running_reg)
                        sec_next = sec_reg + rtcc_pkg::SEC_ADV2_STEP;
                end
                default: ;
            endcase
        end
    end

    // output register with one skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_irq_next    = out_irq_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_irq_next   = skid_irq_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_irq_next    = skid_irq_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_val;
                out_irq_next   = irq_act_next;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = rd_val;
            skid_irq_next   = irq_act_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_reg       <= 1'b0;
            stop_ok_reg    <= 1'b0;
            sec_reg        <= '0;
            us_sub_reg     <= '0;
            ms_ones_reg    <= '0;
            ms_tens_reg    <= '0;
            tenths_reg     <= '0;
            running_reg    <= 1'b1;
            irq_en_reg     <= 1'b0;
            irq_act_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == rtcc_pkg::CFG_LEAP)
                    leap_reg <= cfg_data;
                else
                    stop_ok_reg <= cfg_data;
            end
            if (in_fire)
            begin
                sec_reg     <= sec_next;
                us_sub_reg  <= us_sub_next;
                ms_ones_reg <= ms_ones_next;
                ms_tens_reg <= ms_tens_next;
                tenths_reg  <= tenths_next;
                running_reg <= running_next;
                irq_en_reg  <= irq_en_next;
                irq_act_reg <= irq_act_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_irq_reg   <= out_irq_next;
        skid_data_reg <= skid_data_next;
        skid_irq_reg  <= skid_irq_next;
    end

    // the skid slot only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while output is empty");

    // decimal digits never leave their range
    a_digits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (us_sub_reg <= rtcc_pkg::US_SUB_LAST) && (ms_ones_reg <= rtcc_pkg::DIGIT_LAST)
        && (ms_tens_reg <= rtcc_pkg::DIGIT_LAST) && (tenths_reg <= rtcc_pkg::DIGIT_LAST))
        else $error("microsecond digit out of range");

    // a tick on a stopped clock leaves the time alone
    a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (action == rtcc_pkg::ACT_TICK) && !running_reg)
        |=> ($stable(sec_reg) && $stable(us_sub_reg) && $stable(tenths_reg)))
        else $error("stopped clock advanced on a tick");

    // an accepted beat with a free output shows up in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire
